// ===== rtl/led_matrix_framebuffer_scan_assert.svh =====
// ----------------------------------------------------------------------------
// LED matrix frame store assertion macros
// Shared property forms for the concurrent checks on the scan block.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_FRAMEBUFFER_SCAN_ASSERT_SVH
`define LED_MATRIX_FRAMEBUFFER_SCAN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMFS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lmfs_pkg.sv =====
// ----------------------------------------------------------------------------
// LED matrix frame store package
// Codes, sizes, reset values and shared types for the column scan block.
// ----------------------------------------------------------------------------
package lmfs_pkg;

	// Default geometry of the matrix.
	localparam int DEF_COLUMNS  = 16;
	localparam int DEF_RGB_ROWS = 10;

	// Column word and the byte digit used to move it.
	localparam int WORD_W  = 32;
	localparam int DIGIT_W = 8;
	localparam int DIGITS  = WORD_W / DIGIT_W;
	localparam int DCNT_W  = $clog2(DIGITS + 1);

	// Column index carried between modules, wide enough for the default of 16 columns.
	localparam int IDX_W = 4;

	// Actions of a request.
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_FILL  = 2'd2;
	localparam logic [1:0] ACT_SCAN  = 2'd3;

	// Kinds of result.
	localparam logic [1:0] KIND_ACK  = 2'd0;
	localparam logic [1:0] KIND_PIX  = 2'd1;
	localparam logic [1:0] KIND_SCAN = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_COLUMN_HOLD = 1'b0;
	localparam logic CFG_MONO_CODE   = 1'b1;

	// Configuration reset values.
	localparam logic [15:0] HOLD_RESET = 16'd50;
	localparam logic [3:0]  MONO_RESET = 4'd8;

	// Mono rows and their bits in a column word.
	localparam logic [7:0] MONO_LO_ROW = 8'd10;
	localparam logic [7:0] MONO_HI_ROW = 8'd11;
	localparam int         MONO_LO_BIT = 30;
	localparam int         MONO_HI_BIT = 31;

	// Scan pass limit.
	localparam logic [2:0] MAX_PASSES = 3'd4;

	// Store port controls from the sequencer.
	typedef struct packed {
		logic              wr_en;
		logic [IDX_W-1:0]  wr_addr;
		logic [WORD_W-1:0] wr_data;
		logic [IDX_W-1:0]  rd_addr;
	} store_ctrl_t;

	// Serialiser load request.
	typedef struct packed {
		logic              load;
		logic [WORD_W-1:0] word;
	} ser_ctrl_t;

	// Column word with every RGB row set to one colour and the mono rows set alike.
	function automatic logic [WORD_W-1:0] fill_word(input logic [2:0] rgb, input logic mono,
		input int rgb_rows);
		logic [WORD_W-1:0] w;
		w = '0;
		for (int i = 0; i < DEF_RGB_ROWS; i++) begin
			if (i < rgb_rows) begin
				w[3*i +: 3] = rgb;
			end
		end
		w[MONO_LO_BIT] = mono;
		w[MONO_HI_BIT] = mono;
		return w;
	endfunction

endpackage

// ===== rtl/led_matrix_framebuffer_scan.sv =====
// ----------------------------------------------------------------------------
// LED matrix frame store with column scan
// Pixel access, fill and column scan over a store of column words.
// ----------------------------------------------------------------------------
// Requests arrive on the cmd channel (cmd_valid, cmd_stall) and results leave
// on the res channel (res_valid, res_stall); a transfer happens on a rising
// edge with valid high and stall low. The block takes one request at a time:
// cmd_stall is low only while the sequencer is idle, and a result left in the
// output register does not hold off the next request.
// A write or a read passes through S_PIX and S_RESP to the output register,
// an empty scan through S_RESP alone. A fill sweeps the store one column a
// cycle in S_FILL and then gives its result from S_RESP.
// A scan gives COLUMNS results per pass, up to four passes. Each column takes
// one store read, one load, four byte shifts, a check that the serialiser has
// finished and an emit; the per-column dwell counter loaded from column_hold
// holds the emit back until it has run down to zero.
// When the receiver stalls, the finished result waits in the output register
// and the sequencer waits before the next one; nothing is dropped.
// Reset clears the store to zero, sets column_hold to 50 and mono_code to 8.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once. The
// user must make them only while no request is in progress (not enforced).
// ----------------------------------------------------------------------------
`include "led_matrix_framebuffer_scan_assert.svh"

module led_matrix_framebuffer_scan #(
	parameter int COLUMNS  = lmfs_pkg::DEF_COLUMNS,
	parameter int RGB_ROWS = lmfs_pkg::DEF_RGB_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// Request channel
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  column_x,
	input  logic [7:0]  row_y,
	input  logic [3:0]  color,
	input  logic [2:0]  scan_passes,
	// Result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  kind,
	output logic [3:0]  pixel_color,
	output logic [3:0]  column_select,
	output logic [31:0] column_word,
	output logic        last
);

	localparam int CW = $clog2(COLUMNS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PIX,
		S_FILL,
		S_RESP,
		S_SREAD,
		S_SLOAD,
		S_SSHIFT,
		S_SEMIT
	} state_t;

	state_t      state_q;
	logic [15:0] hold_q;
	logic [3:0]  mono_code_q;

	logic [1:0]  act_q;
	logic [7:0]  col_q;
	logic [7:0]  row_q;
	logic [3:0]  color_q;
	logic [2:0]  passes_q;
	logic [CW-1:0] sel_q;
	logic [15:0] dwell_q;
	logic [lmfs_pkg::WORD_W-1:0] fill_q;
	logic [1:0]  resp_kind_q;
	logic [3:0]  resp_pix_q;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [3:0]  out_pix_q;
	logic [3:0]  out_sel_q;
	logic [31:0] out_word_q;
	logic        out_last_q;

	lmfs_pkg::store_ctrl_t       st_ctrl;
	lmfs_pkg::ser_ctrl_t         ser_ctrl;
	logic [lmfs_pkg::WORD_W-1:0] st_rd_data;
	logic [lmfs_pkg::WORD_W-1:0] ser_word;
	logic                        ser_busy;

	logic        cmd_acc;
	logic        out_free;
	logic        emit;
	logic        in_col;
	logic        row_rgb;
	logic        row_mono;
	logic        mono_match;
	logic        mono_bit;
	logic [4:0]  rgb_sh;
	logic [lmfs_pkg::WORD_W-1:0] rgb_mask;
	logic [lmfs_pkg::WORD_W-1:0] pix_word;
	logic [2:0]  rgb_val;
	logic [3:0]  pix_val;
	logic        pix_hit;
	logic        scan_last;
	logic [2:0]  passes_sat;
	logic [CW-1:0] scan_col;

	assign cmd_acc  = cmd_valid && !cmd_stall;
	assign out_free = !out_valid_q || !res_stall;
	assign cmd_stall = (state_q != S_IDLE);

	// A new result enters the output register in this cycle.
	assign emit = out_free && ((state_q == S_RESP) || (state_q == S_SEMIT && dwell_q == '0));

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q      <= lmfs_pkg::HOLD_RESET;
			mono_code_q <= lmfs_pkg::MONO_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lmfs_pkg::CFG_COLUMN_HOLD: hold_q      <= cfg_data;
				lmfs_pkg::CFG_MONO_CODE:   mono_code_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Pixel position decode for write and read.
	assign in_col     = (col_q < 8'(COLUMNS));
	assign row_rgb    = (row_q < 8'(RGB_ROWS));
	assign row_mono   = (row_q == lmfs_pkg::MONO_LO_ROW) || (row_q == lmfs_pkg::MONO_HI_ROW);
	assign mono_match = (color_q == mono_code_q);
	assign rgb_sh     = ({1'b0, row_q[3:0]} << 1) + {1'b0, row_q[3:0]};
	assign rgb_mask   = lmfs_pkg::WORD_W'(3'b111) << rgb_sh;
	assign rgb_val    = 3'(st_rd_data >> rgb_sh);
	assign mono_bit   = (row_q == lmfs_pkg::MONO_LO_ROW) ? st_rd_data[lmfs_pkg::MONO_LO_BIT]
		: st_rd_data[lmfs_pkg::MONO_HI_BIT];
	assign pix_hit    = in_col && (row_rgb || row_mono);

	// New column word for a pixel write, from the word just read.
	always_comb begin
		pix_word = st_rd_data;
		if (row_rgb) begin
			pix_word = (st_rd_data & ~rgb_mask)
				| (lmfs_pkg::WORD_W'(color_q[2:0]) << rgb_sh);
		end else if (row_q == lmfs_pkg::MONO_LO_ROW) begin
			pix_word[lmfs_pkg::MONO_LO_BIT] = mono_match;
		end else begin
			pix_word[lmfs_pkg::MONO_HI_BIT] = mono_match;
		end
	end

	// Value returned for a pixel read.
	always_comb begin
		pix_val = '0;
		if (in_col) begin
			if (row_rgb) begin
				pix_val = {1'b0, rgb_val};
			end else if (row_mono && mono_bit) begin
				pix_val = mono_code_q;
			end
		end
	end

	assign passes_sat = (scan_passes > lmfs_pkg::MAX_PASSES) ? lmfs_pkg::MAX_PASSES
		: scan_passes;
	assign scan_col   = CW'(COLUMNS - 1) - sel_q;
	assign scan_last  = (sel_q == CW'(COLUMNS - 1)) && (passes_q == 3'd1);

	// Store and serialiser controls.
	always_comb begin
		st_ctrl.wr_en   = 1'b0;
		st_ctrl.wr_addr = lmfs_pkg::IDX_W'(sel_q);
		st_ctrl.wr_data = fill_q;
		st_ctrl.rd_addr = lmfs_pkg::IDX_W'(scan_col);
		if (state_q == S_IDLE) begin
			st_ctrl.rd_addr = lmfs_pkg::IDX_W'(column_x[CW-1:0]);
		end
		if (state_q == S_FILL) begin
			st_ctrl.wr_en = 1'b1;
		end else if (state_q == S_PIX && act_q == lmfs_pkg::ACT_WRITE && pix_hit) begin
			st_ctrl.wr_en   = 1'b1;
			st_ctrl.wr_addr = lmfs_pkg::IDX_W'(col_q[CW-1:0]);
			st_ctrl.wr_data = pix_word;
		end
		ser_ctrl.load = (state_q == S_SLOAD);
		ser_ctrl.word = st_rd_data;
	end

	lmfs_store #(
		.COLUMNS(COLUMNS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (st_ctrl),
		.rd_data(st_rd_data)
	);

	lmfs_ser u_ser (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ser_ctrl),
		.busy  (ser_busy),
		.word  (ser_word)
	);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			passes_q    <= '0;
			sel_q       <= '0;
			dwell_q     <= '0;
			act_q       <= lmfs_pkg::ACT_WRITE;
			resp_kind_q <= lmfs_pkg::KIND_ACK;
		end else begin
			if (!res_stall && !emit) begin
				out_valid_q <= 1'b0;
			end
			if (dwell_q != '0 && state_q != S_SLOAD) begin
				dwell_q <= dwell_q - 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						act_q       <= action;
						col_q       <= column_x;
						row_q       <= row_y;
						color_q     <= color;
						passes_q    <= passes_sat;
						sel_q       <= '0;
						fill_q      <= lmfs_pkg::fill_word(color[2:0], color == mono_code_q,
							RGB_ROWS);
						resp_kind_q <= lmfs_pkg::KIND_ACK;
						resp_pix_q  <= '0;
						case (action)
							lmfs_pkg::ACT_WRITE,
							lmfs_pkg::ACT_READ: state_q <= S_PIX;
							lmfs_pkg::ACT_FILL: state_q <= S_FILL;
							default: begin
								state_q <= (passes_sat == 3'd0) ? S_RESP : S_SREAD;
							end
						endcase
					end
				end
				S_PIX: begin
					if (act_q == lmfs_pkg::ACT_READ) begin
						resp_kind_q <= lmfs_pkg::KIND_PIX;
						resp_pix_q  <= pix_val;
					end
					state_q <= S_RESP;
				end
				S_FILL: begin
					sel_q <= sel_q + 1'b1;
					if (sel_q == CW'(COLUMNS - 1)) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= resp_kind_q;
						out_pix_q   <= resp_pix_q;
						out_sel_q   <= '0;
						out_word_q  <= '0;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_SREAD: begin
					state_q <= S_SLOAD;
				end
				S_SLOAD: begin
					dwell_q <= hold_q;
					state_q <= S_SSHIFT;
				end
				S_SSHIFT: begin
					if (!ser_busy) begin
						state_q <= S_SEMIT;
					end
				end
				S_SEMIT: begin
					if (out_free && dwell_q == '0) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= lmfs_pkg::KIND_SCAN;
						out_pix_q   <= '0;
						out_sel_q   <= 4'(sel_q);
						out_word_q  <= ser_word;
						out_last_q  <= scan_last;
						if (scan_last) begin
							state_q <= S_IDLE;
						end else begin
							if (sel_q == CW'(COLUMNS - 1)) begin
								sel_q    <= '0;
								passes_q <= passes_q - 1'b1;
							end else begin
								sel_q <= sel_q + 1'b1;
							end
							state_q <= S_SREAD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid     = out_valid_q;
	assign kind          = out_kind_q;
	assign pixel_color   = out_pix_q;
	assign column_select = out_sel_q;
	assign column_word   = out_word_q;
	assign last          = out_last_q;

	// Only scanned columns may come without the last mark.
	`LMFS_ASSERT_SAME(a_last_single, res_valid && kind != lmfs_pkg::KIND_SCAN, last,
		"single result without last mark")

	// A taken request closes the request channel in the next cycle.
	`LMFS_ASSERT_NEXT(a_cmd_closed, cmd_valid && !cmd_stall, cmd_stall,
		"request channel open while a request is in progress")

	// The last scanned column returns the sequencer to idle.
	`LMFS_ASSERT_NEXT(a_scan_end,
		state_q == S_SEMIT && out_free && dwell_q == '0 && scan_last, !cmd_stall,
		"sequencer busy after the final scanned column")

endmodule

// ===== rtl/lmfs_store.sv =====
// ----------------------------------------------------------------------------
// LED matrix frame store
// One column word per entry, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module lmfs_store #(
	parameter int COLUMNS = lmfs_pkg::DEF_COLUMNS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lmfs_pkg::store_ctrl_t       ctrl,
	output logic [lmfs_pkg::WORD_W-1:0] rd_data
);

	localparam int AW = $clog2(COLUMNS);

	logic [lmfs_pkg::WORD_W-1:0] mem_q [COLUMNS];
	logic [lmfs_pkg::WORD_W-1:0] rd_data_q;

	// Column words are cleared at reset so that a blank matrix scans as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COLUMNS; i++) begin
				mem_q[i] <= '0;
			end
		end else if (ctrl.wr_en) begin
			mem_q[ctrl.wr_addr[AW-1:0]] <= ctrl.wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[ctrl.rd_addr[AW-1:0]];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/lmfs_ser.sv =====
// ----------------------------------------------------------------------------
// LED matrix column serialiser
// Shifts a column word out one byte a cycle, most significant byte first,
// and gathers the bytes into the word presented to the row drivers.
// ----------------------------------------------------------------------------
module lmfs_ser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lmfs_pkg::ser_ctrl_t         ctrl,
	output logic                        busy,
	output logic [lmfs_pkg::WORD_W-1:0] word
);

	logic [lmfs_pkg::WORD_W-1:0] shift_q;
	logic [lmfs_pkg::WORD_W-1:0] gather_q;
	logic [lmfs_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;

	// Byte counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (ctrl.load) begin
			cnt_q  <= lmfs_pkg::DCNT_W'(lmfs_pkg::DIGITS);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == lmfs_pkg::DCNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Byte-wide shift path from the source word into the gathered word.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			shift_q <= ctrl.word;
		end else if (busy_q) begin
			shift_q  <= shift_q << lmfs_pkg::DIGIT_W;
			gather_q <= {gather_q[lmfs_pkg::WORD_W-lmfs_pkg::DIGIT_W-1:0],
				shift_q[lmfs_pkg::WORD_W-1 -: lmfs_pkg::DIGIT_W]};
		end
	end

	assign busy = busy_q;
	assign word = gather_q;

endmodule
